// File: rtl/sxf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sprite XOR frame buffer.
// Used by sxf_frame_mem, sxf_line_xor and sprite_xor_framebuffer_top.
package sxf_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int LINE_W        = $clog2(SCREEN_HEIGHT);
    localparam int SPRITE_W      = 8;
    localparam int ROW_IDX_W     = 4;
    localparam int REQ_W         = 2;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 72;

    typedef enum logic [REQ_W-1:0] {
        REQ_DRAW  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        logic                    rd_en;
        logic [LINE_W-1:0]       rd_addr;
        logic                    wr_en;
        logic [LINE_W-1:0]       wr_addr;
        logic [SCREEN_WIDTH-1:0] wr_data;
        logic                    clr;
    } t_mem_req;

endpackage

// File: rtl/sxf_frame_mem.sv
`timescale 1ns / 1ps
// Frame line memory, one synchronous read port and one write port.
// Per-line valid bits make unwritten or cleared lines read as zero. Uses sxf_pkg.
module sxf_frame_mem (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sxf_pkg::t_mem_req               i_req,
    output logic [sxf_pkg::SCREEN_WIDTH-1:0] o_rd_data
);

    logic [sxf_pkg::SCREEN_WIDTH-1:0]  r_mem [sxf_pkg::SCREEN_HEIGHT];
    logic [sxf_pkg::SCREEN_HEIGHT-1:0] r_valid;
    logic [sxf_pkg::SCREEN_WIDTH-1:0]  r_rd_data;
    logic                              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_vld  <= r_valid[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: rtl/sxf_line_xor.sv
`timescale 1ns / 1ps
// Sprite row placement and XOR into one frame line, with collision detect.
// Columns past the right edge drop off the shifted mask. Uses sxf_pkg.
module sxf_line_xor (
    input  logic [sxf_pkg::COL_W-1:0]        i_col,
    input  logic [sxf_pkg::SPRITE_W-1:0]     i_bits,
    input  logic [sxf_pkg::SCREEN_WIDTH-1:0] i_line,
    output logic [sxf_pkg::SCREEN_WIDTH-1:0] o_line,
    output logic                             o_hit
);

    logic [sxf_pkg::SPRITE_W-1:0]     rev;
    logic [sxf_pkg::SCREEN_WIDTH-1:0] mask;

    always_comb begin
        for (int c = 0; c < sxf_pkg::SPRITE_W; c++) begin
            rev[c] = i_bits[sxf_pkg::SPRITE_W-1-c];
        end
        mask   = sxf_pkg::SCREEN_WIDTH'(rev) << i_col;
        o_hit  = |(i_line & mask);
        o_line = i_line ^ mask;
    end

endmodule

// File: rtl/sprite_xor_framebuffer_top.sv
`timescale 1ns / 1ps
// Top level of the sprite XOR frame buffer: control sequencer and output register.
// Depends on sxf_pkg, sxf_frame_mem and sxf_line_xor.
//
// Input channel (s_axis): tuser carries the request kind (draw row, clear, read line),
// tlast marks the last row of a draw, tdata carries origin, row index, sprite bits
// and read line. Output channel (m_axis): one item per input item, with the
// collision flag and a 64-bit line.
// Each draw item that falls on the screen does one read-modify-write of a single frame line: the line is read
// from the memory in the accept cycle, merged and written back in the next cycle,
// and the result sits in the output register in the cycle after that.
// Items do not overlap: the memory read is followed by the write-back, and a new
// item is taken only in the idle state, in the cycle the previous result leaves
// or while the output register is empty.
// Reset empties the frame at once through per-line valid bits and clears the
// accumulated collision flag; a clear item does the same to the frame.
// While the receiver stalls, the result holds and no new item is taken.
module sprite_xor_framebuffer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [7:0] origin_x, [15:8] origin_y, [19:16] row_index, [27:20] sprite_bits,
    // [32:28] read_line, [39:33] zero
    input  logic [sxf_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // [1:0] req_type
    input  logic [sxf_pkg::REQ_W-1:0]           i_s_axis_tuser,
    // last_row
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] collision, [64:1] line_bits, [71:65] zero
    output logic [sxf_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RMW  = 2'b10
    } t_state;

    t_state                           r_state, n_state;
    sxf_pkg::t_req                    r_req;
    logic [sxf_pkg::COL_W-1:0]        r_col;
    logic [sxf_pkg::LINE_W-1:0]       r_line;
    logic                             r_clip;
    logic [sxf_pkg::SPRITE_W-1:0]     r_bits;
    logic                             r_last;
    logic                             r_acc, n_acc;
    logic                             r_out_valid, n_out_valid;
    logic                             r_out_coll, n_out_coll;
    logic [sxf_pkg::SCREEN_WIDTH-1:0] r_out_line, n_out_line;

    logic                             in_acc;
    logic [sxf_pkg::LINE_W:0]         tgt_y;
    sxf_pkg::t_mem_req                mem_req;
    logic [sxf_pkg::SCREEN_WIDTH-1:0] rd_data;
    logic [sxf_pkg::SCREEN_WIDTH-1:0] xor_line;
    logic                             hit;
    logic                             coll_now;

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign tgt_y = {1'b0, i_s_axis_tdata[12:8]}
                 + (sxf_pkg::LINE_W + 1)'(i_s_axis_tdata[19:16]);

    sxf_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    sxf_line_xor u_xor (
        .i_col  (r_col),
        .i_bits (r_bits),
        .i_line (rd_data),
        .o_line (xor_line),
        .o_hit  (hit)
    );

    assign coll_now = r_acc | hit;

    always_comb begin
        mem_req         = '0;
        mem_req.rd_en   = in_acc;
        mem_req.rd_addr = (sxf_pkg::t_req'(i_s_axis_tuser) == sxf_pkg::REQ_READ)
                        ? i_s_axis_tdata[32:28] : tgt_y[sxf_pkg::LINE_W-1:0];
        mem_req.wr_addr = r_line;
        mem_req.wr_data = xor_line;
        n_state     = r_state;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_coll  = r_out_coll;
        n_out_line  = r_out_line;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_RMW;
                end
            end
            ST_RMW: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_out_coll  = 1'b0;
                n_out_line  = '0;
                case (r_req)
                    sxf_pkg::REQ_DRAW: begin
                        if (r_clip) begin
                            n_out_coll = r_acc;
                        end else begin
                            mem_req.wr_en = 1'b1;
                            n_out_coll    = coll_now;
                            n_out_line    = xor_line;
                        end
                        n_acc = r_last ? 1'b0 : n_out_coll;
                    end
                    sxf_pkg::REQ_CLEAR: begin
                        mem_req.clr = 1'b1;
                    end
                    sxf_pkg::REQ_READ: begin
                        n_out_line = rd_data;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_coll <= n_out_coll;
        r_out_line <= n_out_line;
        if (in_acc) begin
            r_req  <= sxf_pkg::t_req'(i_s_axis_tuser);
            r_col  <= i_s_axis_tdata[sxf_pkg::COL_W-1:0];
            r_line <= tgt_y[sxf_pkg::LINE_W-1:0];
            r_clip <= tgt_y[sxf_pkg::LINE_W];
            r_bits <= i_s_axis_tdata[27:20];
            r_last <= i_s_axis_tlast;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_line, r_out_coll};

endmodule
